/* rtl/core/pbs_pkg.sv */
`default_nettype none

package pbs_pkg;

  // Field widths of the input and result words.
  localparam int CMD_W = 2;
  localparam int IDX_W = 12;
  localparam int VAL_W = 16;
  localparam int CFG_W = 5;

  // Reset value of the element width register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

  // Defaults for the top level parameters.
  localparam int STORE_BITS_DEF       = 4096;
  localparam int MAX_ELEMENT_BITS_DEF = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE1 = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE2 = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE4 = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/pbs_ram.sv */
`default_nettype none

module pbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/packed_bitfield_store.sv */
`default_nettype none
// A read word reads RD_BYTES store bytes, each in ST_RD then ST_WR, then forms its result
// in ST_FIN and shows it in ST_OUT. A write word places one to four copies in ST_BUILD,
// then does one read-modify-write of the byte-wide store per byte touched (ST_RD, ST_WR).
// One word at a time: a new word is taken only once the previous one is done,
// and the byte-wide memory port sets the pace of the byte loop.
// Reset (rst_n low, synchronous) returns the sequencer to idle and the element width to 8.

module packed_bitfield_store #(
  parameter int STORE_BITS       = pbs_pkg::STORE_BITS_DEF,
  parameter int MAX_ELEMENT_BITS = pbs_pkg::MAX_ELEMENT_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pbs_pkg::CMD_W-1:0]   in_command,
  input  wire logic [pbs_pkg::IDX_W-1:0]   in_element_index,
  input  wire logic [pbs_pkg::VAL_W-1:0]   in_write_value,

  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [pbs_pkg::VAL_W-1:0]   out_read_value,

  input  wire logic                        cfg_wr_en,
  input  wire logic [pbs_pkg::CFG_W-1:0]   cfg_wr_data
);

  // The store is a byte-wide memory; bit position p lives in byte p/8, bit p%8.
  // STORE_BITS is expected to be a multiple of eight.
  localparam int DEPTH = STORE_BITS / 8;
  localparam int AW    = $clog2(DEPTH);

  // Effective element width and the bit offset of an element.
  localparam int WB     = $clog2(MAX_ELEMENT_BITS + 1);
  localparam int BASE_W = pbs_pkg::IDX_W + WB;

  // The byte address needs room for the span of one word past the last byte
  // and for a comparison against the store depth.
  localparam int BA_A = BASE_W - 2;
  localparam int BA_W = (BA_A > AW + 1) ? BA_A : AW + 1;

  // A write pattern holds up to four copies placed at the sub-byte offset.
  localparam int PAT_W = 7 + 4 * MAX_ELEMENT_BITS;
  localparam int OFF_W = $clog2(PAT_W + 1);

  // A read spans the sub-byte offset plus at most sixteen element bits.
  localparam int RD_BITS  = (MAX_ELEMENT_BITS < pbs_pkg::VAL_W) ?
                            MAX_ELEMENT_BITS : pbs_pkg::VAL_W;
  localparam int RD_BYTES = (7 + RD_BITS + 7) / 8;
  localparam int ACC_W    = 8 * RD_BYTES;
  localparam int CNT_W    = $clog2(RD_BYTES + 1);

  // Sequencer states.
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_BUILD = 3'd1;
  localparam logic [ST_W-1:0] ST_RD    = 3'd2;
  localparam logic [ST_W-1:0] ST_WR    = 3'd3;
  localparam logic [ST_W-1:0] ST_FIN   = 3'd4;
  localparam logic [ST_W-1:0] ST_OUT   = 3'd5;

  logic [ST_W-1:0]           state_r, state_nxt;
  logic [pbs_pkg::CFG_W-1:0] cfg_r, cfg_nxt;
  logic                      is_read_r, is_read_nxt;
  logic [2:0]                copies_r, copies_nxt;
  logic [2:0]                sh_r, sh_nxt;
  logic [BA_W-1:0]           addr_r, addr_nxt;
  logic [OFF_W-1:0]          off_r, off_nxt;
  logic [PAT_W-1:0]          pat_r, pat_nxt;
  logic [PAT_W-1:0]          msk_r, msk_nxt;
  logic [pbs_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [pbs_pkg::VAL_W-1:0] rd_val_r, rd_val_nxt;

  // Element width in use: the register value, saturated to the maximum width.
  logic [pbs_pkg::CFG_W:0]   w_sat;
  logic [WB-1:0]             w;
  logic [pbs_pkg::VAL_W:0]   one_sh;
  logic [pbs_pkg::VAL_W-1:0] wmask;
  logic [BASE_W-1:0]         base;

  // Memory port signals.
  logic                      ram_we;
  logic [7:0]                ram_wdata;
  logic                      ram_re;
  logic [7:0]                ram_rdata;
  logic                      addr_in_range;
  logic [7:0]                byte_data;
  logic [PAT_W-1:0]          pat_sh, msk_sh;
  logic [ACC_W+7:0]          acc_cat;

  assign w_sat = ({1'b0, cfg_r} > (pbs_pkg::CFG_W + 1)'(MAX_ELEMENT_BITS)) ?
                 (pbs_pkg::CFG_W + 1)'(MAX_ELEMENT_BITS) : {1'b0, cfg_r};
  assign w     = WB'(w_sat);

  // Low min(w, 16) bits set; only those element bits are ever stored or returned.
  assign one_sh = (pbs_pkg::VAL_W + 1)'(1) << w;
  assign wmask  = one_sh[pbs_pkg::VAL_W-1:0] - pbs_pkg::VAL_W'(1);

  // First bit position of the addressed element.
  assign base = BASE_W'(in_element_index) * BASE_W'(w);

  // Bytes past the end of the store read as zero and are never written.
  assign addr_in_range = (addr_r < BA_W'(DEPTH));
  assign byte_data     = addr_in_range ? ram_rdata : 8'd0;

  assign pat_sh  = pat_r >> 8;
  assign msk_sh  = msk_r >> 8;
  assign acc_cat = {byte_data, acc_r};

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_read_value = rd_val_r;

  always_comb begin
    state_nxt   = state_r;
    cfg_nxt     = cfg_wr_en ? cfg_wr_data : cfg_r;
    is_read_nxt = is_read_r;
    copies_nxt  = copies_r;
    sh_nxt      = sh_r;
    addr_nxt    = addr_r;
    off_nxt     = off_r;
    pat_nxt     = pat_r;
    msk_nxt     = msk_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    rd_val_nxt  = rd_val_r;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = (byte_data & ~msk_r[7:0]) | (pat_r[7:0] & msk_r[7:0]);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          is_read_nxt = (in_command == pbs_pkg::CMD_READ);
          sh_nxt      = base[2:0];
          addr_nxt    = BA_W'(base >> 3);
          off_nxt     = OFF_W'(base[2:0]);
          pat_nxt     = '0;
          msk_nxt     = '0;
          val_nxt     = in_write_value & wmask;
          cnt_nxt     = '0;
          case (in_command)
            pbs_pkg::CMD_WRITE1: copies_nxt = 3'd1;
            pbs_pkg::CMD_WRITE2: copies_nxt = 3'd2;
            default:             copies_nxt = 3'd4;
          endcase
          state_nxt = (in_command == pbs_pkg::CMD_READ) ? ST_RD : ST_BUILD;
        end
      end

      // One copy of the value is placed per cycle through the shared shifter.
      ST_BUILD: begin
        pat_nxt    = pat_r | (PAT_W'(val_r) << off_r);
        msk_nxt    = msk_r | (PAT_W'(wmask) << off_r);
        off_nxt    = off_r + OFF_W'(w);
        copies_nxt = copies_r - 3'd1;
        if (copies_r == 3'd1) begin
          // A zero element width leaves nothing to write.
          state_nxt = (wmask == '0) ? ST_IDLE : ST_RD;
        end
      end

      ST_RD: begin
        ram_re    = addr_in_range;
        state_nxt = ST_WR;
      end

      // Read data is back: merge for a write, collect for a read.
      ST_WR: begin
        addr_nxt = addr_r + BA_W'(1);
        if (is_read_r) begin
          acc_nxt = acc_cat[ACC_W+7:8];
          cnt_nxt = cnt_r + CNT_W'(1);
          state_nxt = (cnt_r == CNT_W'(RD_BYTES - 1)) ? ST_FIN : ST_RD;
        end else begin
          ram_we  = addr_in_range && (msk_r[7:0] != 8'd0);
          pat_nxt = pat_sh;
          msk_nxt = msk_sh;
          state_nxt = (msk_sh == '0) ? ST_IDLE : ST_RD;
        end
      end

      ST_FIN: begin
        rd_val_nxt = pbs_pkg::VAL_W'(acc_r >> sh_r) & wmask;
        state_nxt  = ST_OUT;
      end

      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cfg_r   <= pbs_pkg::CFG_RESET;
    end else begin
      state_r <= state_nxt;
      cfg_r   <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r <= is_read_nxt;
    copies_r  <= copies_nxt;
    sh_r      <= sh_nxt;
    addr_r    <= addr_nxt;
    off_r     <= off_nxt;
    pat_r     <= pat_nxt;
    msk_r     <= msk_nxt;
    val_r     <= val_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    rd_val_r  <= rd_val_nxt;
  end

  pbs_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r[AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr_r[AW-1:0]),
    .rdata(ram_rdata)
  );

endmodule

`default_nettype wire

/* tb/packed_bitfield_store_checker.sv */
module packed_bitfield_store_checker
  import pbs_pkg::*;
#(
  parameter int STORE_BITS       = STORE_BITS_DEF,
  parameter int MAX_ELEMENT_BITS = MAX_ELEMENT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_element_index,
  input  logic [VAL_W-1:0] in_write_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [VAL_W-1:0] out_read_value,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output int               fail_count,
  output int               outstanding
);

  logic [CFG_W-1:0]      width_reg;
  logic [STORE_BITS-1:0] shadow_bits;
  logic [VAL_W-1:0]      read_values [$];
  int                    fails = 0;

  // Widths above the maximum saturate; zero means nothing is stored.
  function automatic int active_width(logic [CFG_W-1:0] raw);
    int w;
    w = int'(raw);
    if (w > MAX_ELEMENT_BITS) w = MAX_ELEMENT_BITS;
    return w;
  endfunction

  // Bits past the end of the store read as zero.
  function automatic logic [VAL_W-1:0] stored_element(int idx, int w);
    logic [VAL_W-1:0] v;
    int pos;
    v = '0;
    for (int i = 0; i < w && i < VAL_W; i++) begin
      pos = idx * w + i;
      if (pos < STORE_BITS) v[i] = shadow_bits[pos];
    end
    return v;
  endfunction

  function automatic void fill_elements(int idx, int copies, int w, logic [VAL_W-1:0] v);
    int pos;
    for (int k = 0; k < copies; k++) begin
      for (int i = 0; i < w && i < VAL_W; i++) begin
        pos = (idx + k) * w + i;
        if (pos < STORE_BITS) shadow_bits[pos] = v[i];
      end
    end
  endfunction

  always @(posedge clk) begin
    int w;
    int copies;
    logic [VAL_W-1:0] want;
    if (!rst_n) begin
      width_reg = CFG_RESET;
      read_values.delete();
    end else begin
      if (cfg_wr_en) width_reg = cfg_wr_data;

      if (out_valid && out_ready) begin
        if (read_values.size() == 0) begin
          $error("out_read_value: expected no word, got %04h", out_read_value);
          fails++;
        end else begin
          want = read_values.pop_front();
          if (out_read_value !== want) begin
            $error("out_read_value: expected %04h, got %04h", want, out_read_value);
            fails++;
          end
        end
      end

      if (in_valid && in_ready) begin
        w = active_width(width_reg);
        copies = 0;
        case (in_command)
          CMD_READ:   read_values.push_back(stored_element(int'(in_element_index), w));
          CMD_WRITE1: copies = 1;
          CMD_WRITE2: copies = 2;
          CMD_WRITE4: copies = 4;
          default:    copies = 0;
        endcase
        if (copies != 0) fill_elements(int'(in_element_index), copies, w, in_write_value);
      end
    end
    outstanding <= read_values.size();
    fail_count  <= fails;
  end

endmodule

/* tb/tb_packed_bitfield_store.sv */
module tb_packed_bitfield_store;
  import pbs_pkg::*;

  localparam int STORE_BITS   = STORE_BITS_DEF;
  localparam int MAX_W        = MAX_ELEMENT_BITS_DEF;
  localparam int LAST_INDEX   = (1 << IDX_W) - 1;
  // A write word can keep the block busy with no result to show for it, so every
  // width change waits comfortably longer than the longest write word takes.
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_WORDS = 86;
  localparam int CYCLE_LIMIT  = 400000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_command;
  logic [IDX_W-1:0] in_element_index;
  logic [VAL_W-1:0] in_write_value;
  logic             out_valid;
  logic             out_ready;
  logic [VAL_W-1:0] out_read_value;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  int fail_count;
  int outstanding;

  // The store comes out of reset with unknown content, so the stimulus keeps its own
  // map of which bit positions have been written and only reads elements whose
  // in-store bits are all covered. Bits past the end of the store need no cover.
  bit written_bits [STORE_BITS];
  // Elements written under the current width; reads mostly come from here so that
  // the random part is dominated by write-then-read pairs.
  int written_elems [$];
  int lane_bits;
  // When calm is set neither side inserts idle cycles.
  bit calm = 1'b0;
  int reads_sent  = 0;
  int writes_sent = 0;
  int widths_run  = 1;
  int cycle_count;

  always #5 clk = ~clk;

  packed_bitfield_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_element_index (in_element_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  packed_bitfield_store_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_element_index (in_element_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  function automatic int lane_width(logic [CFG_W-1:0] raw);
    return (int'(raw) > MAX_W) ? MAX_W : int'(raw);
  endfunction

  function automatic int copies_for(logic [CMD_W-1:0] cmd);
    case (cmd)
      CMD_WRITE1: return 1;
      CMD_WRITE2: return 2;
      CMD_WRITE4: return 4;
      default:    return 0;
    endcase
  endfunction

  // Index of the element that holds the last bit of the store. With a zero width
  // every index is equally empty, so the top of the index range stands in.
  function automatic int tail_index();
    int t;
    if (lane_bits == 0) return LAST_INDEX;
    t = (STORE_BITS - 1) / lane_bits;
    return (t > LAST_INDEX) ? LAST_INDEX : t;
  endfunction

  function automatic bit readable(int idx);
    int pos;
    for (int i = 0; i < lane_bits; i++) begin
      pos = idx * lane_bits + i;
      if (pos < STORE_BITS && !written_bits[pos]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void note_written(logic [CMD_W-1:0] cmd, int idx);
    int pos;
    for (int k = 0; k < copies_for(cmd); k++) begin
      for (int i = 0; i < lane_bits; i++) begin
        pos = (idx + k) * lane_bits + i;
        if (pos < STORE_BITS) written_bits[pos] = 1'b1;
      end
      if (idx + k <= LAST_INDEX) written_elems.push_back(idx + k);
    end
  endfunction

  // Presents one word and holds it until the block takes it. The bookkeeping for
  // writes happens here because the block handles one word at a time, in order,
  // so any later read is sure to see the write.
  task automatic send_word(logic [CMD_W-1:0] cmd, int idx, logic [VAL_W-1:0] val);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_element_index <= IDX_W'(idx);
    in_write_value   <= val;
    if (cmd == CMD_READ) begin
      reads_sent++;
    end else begin
      writes_sent++;
      note_written(cmd, idx);
    end
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic read_element(int idx);
    send_word(CMD_READ, idx, VAL_W'($urandom_range(0, 65535)));
  endtask

  // Drops valid, waits until every read has been answered, and then gives a
  // trailing write time to finish before anything touches the width register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(logic [CFG_W-1:0] raw);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= raw;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lane_bits = lane_width(raw);
    written_elems.delete();
    widths_run++;
  endtask

  // The interesting spots for any width: the element that straddles or touches
  // the end of the store, a four-element fill that runs up to it, the first
  // element entirely past the end, and an all-ones pair at the very start.
  task automatic boundary_words();
    int tail;
    tail = tail_index();
    send_word(CMD_WRITE1, tail, VAL_W'($urandom_range(0, 65535)));
    read_element(tail);
    if (tail >= 3) begin
      send_word(CMD_WRITE4, tail - 3, VAL_W'($urandom_range(0, 65535)));
      read_element(tail - 3);
      read_element(tail);
    end
    if (tail < LAST_INDEX) read_element(tail + 1);
    send_word(CMD_WRITE2, 0, 16'hFFFF);
    read_element(0);
    read_element(1);
  endtask

  // Most reads target an element that was just written; the rest probe random
  // indices, which often land past the store where every bit reads as zero.
  task automatic random_word();
    int span;
    int idx;
    int pick;
    int tries;
    bit found;
    logic [CMD_W-1:0] cmd;
    span = tail_index() + 1;
    if (span > LAST_INDEX) span = LAST_INDEX;
    pick = $urandom_range(0, 99);
    found = 1'b0;
    idx = 0;
    if (pick >= 45) begin
      if (pick < 85 && written_elems.size() > 0) begin
        idx = written_elems[$urandom_range(0, written_elems.size() - 1)];
        found = 1'b1;
      end else begin
        tries = 0;
        while (!found && tries < 8) begin
          idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LAST_INDEX)
                                            : $urandom_range(0, span);
          found = readable(idx);
          tries++;
        end
      end
    end
    if (found) begin
      read_element(idx);
    end else begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_WRITE1;
        1:       cmd = CMD_WRITE2;
        default: cmd = CMD_WRITE4;
      endcase
      idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, LAST_INDEX)
                                        : $urandom_range(0, span);
      send_word(cmd, idx, VAL_W'($urandom_range(0, 65535)));
    end
  endtask

  task automatic random_words(int count);
    repeat (count) random_word();
  endtask

  // The receiver stalls in bursts unless the run is in a calm stretch.
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] widths [9];
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_command       <= CMD_READ;
    in_element_index <= '0;
    in_write_value   <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= CFG_RESET;
    lane_bits = lane_width(CFG_RESET);
    // Both extremes of the usable range, the all-ones and all-zeros register
    // values, two odd widths that straddle the end of the store, a value just past
    // saturation, one random value, and back to the reset width at the end.
    widths = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd3, 5'd13, 5'd17, 5'd0, CFG_RESET};
    widths[7] = CFG_W'($urandom_range(0, 31));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset width: full and empty values, upper value bits
    // that must be ignored, two and four element fills read at both ends, and a
    // write far past the store that must leave nothing behind.
    send_word(CMD_WRITE1, 0, 16'hFFFF);
    read_element(0);
    send_word(CMD_WRITE2, 4, 16'h01A5);
    read_element(4);
    read_element(5);
    send_word(CMD_WRITE4, 8, 16'h005A);
    read_element(8);
    read_element(11);
    send_word(CMD_WRITE1, 0, 16'h0000);
    read_element(0);
    send_word(CMD_WRITE1, LAST_INDEX, 16'hFFFF);
    read_element(LAST_INDEX);
    boundary_words();
    random_words(RANDOM_WORDS);
    settle();

    for (int p = 0; p < 9; p++) begin
      // Some stretches run with no idling at all, and the final one always does.
      calm = (p == 8) || ($urandom_range(0, 3) == 0);
      set_width(widths[p]);
      boundary_words();
      random_words(RANDOM_WORDS);
      settle();
    end

    $display("Covered %0d reads and %0d writes over %0d element widths,", reads_sent,
             writes_sent, widths_run);
    $display("including zero, saturated and store-edge straddling widths.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* packed_bitfield_store.f */
rtl/core/pbs_pkg.sv
rtl/core/pbs_ram.sv
rtl/core/packed_bitfield_store.sv
tb/packed_bitfield_store_checker.sv
tb/tb_packed_bitfield_store.sv
